### rtl/core/cosf_pkg.sv
// Shared types and constants for the cosine angle force pipeline.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none
package cosf_pkg;

  localparam int NUM_GAIN    = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int TYPE_W      = 2;

  typedef struct packed {
    logic [1:0]         angle_type;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
    logic signed [31:0] third_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] energy;
    logic signed [31:0] force_first_x;
    logic signed [31:0] force_first_y;
    logic signed [31:0] force_first_z;
    logic signed [31:0] force_vertex_x;
    logic signed [31:0] force_vertex_y;
    logic signed [31:0] force_vertex_z;
    logic signed [31:0] force_third_x;
    logic signed [31:0] force_third_y;
    logic signed [31:0] force_third_z;
    logic               degenerate;
    logic               saturated;
  } result_t;

  // one normalized bond vector: magnitudes in [0, 2^30), signs, scale exponent
  typedef struct packed {
    logic [2:0][29:0]  mag;
    logic [2:0]        neg;
    logic signed [5:0] e;
  } bond_t;

  // carried alongside the square root
  typedef struct packed {
    bond_t              b1;
    bond_t              b3;
    logic               z1;
    logic               z3;
    logic signed [31:0] k;
  } pre_root_t;

  // carried alongside the unit vector dividers and the middle stages
  typedef struct packed {
    logic [2:0]         neg1;
    logic [2:0]         neg3;
    logic signed [5:0]  e1;
    logic signed [5:0]  e3;
    logic               z1;
    logic               z3;
    logic signed [31:0] k;
    logic [30:0]        l1;
    logic [30:0]        l3;
  } post_root_t;

  // carried alongside the force dividers
  typedef struct packed {
    logic [2:0]         neg1;
    logic [2:0]         neg3;
    logic signed [5:0]  e1;
    logic signed [5:0]  e3;
    logic               z;
    logic signed [33:0] energy;
  } tail_t;

endpackage
`default_nettype wire

### rtl/core/cosine_angle_force.sv
// Cosine angle potential: energy and three atom forces, one angle per cycle unless stalled.
// Depends on cosf_pkg, cosf_norm, cosf_sqrt, cosf_div and cosf_delay.
//
// Usage:
//   Input channel (item_valid / item_stall / item) carries one angle per
//   transaction: a type and three Q16.16 positions, vertex in the middle.
//   Output channel (result_valid / result_stall / result) returns one result
//   transaction per angle, in order: energy, nine forces, degenerate and
//   saturated flags.
//   Configuration: cfg_wr_en with cfg_index / cfg_data writes gain register
//   cfg_index (the stiffness of that angle type). Write only while idle.
// Throughput: one transaction per cycle, sustained while the output is not stalled.
// Pipeline: the depth is set by the 32-digit square root (16 stages), the
//   unit-vector dividers (60 quotient bits, 15 stages) and the force dividers
//   (78 quotient bits, 20 stages), plus 13 arithmetic stages around them.
// Stall: the whole pipeline advances on one enable. While a result waits in
//   the output register under result_stall, every stage holds and item_stall
//   is raised; nothing is lost or repeated.
// Reset (rst, synchronous): clears all valid bits and the gain registers.
`default_nettype none
module cosine_angle_force #(
  parameter int TYPE_COUNT = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  cosf_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output cosf_pkg::result_t                 result,
  input  logic                              cfg_wr_en,
  input  logic [cosf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int GAIN_REGS = (TYPE_COUNT < cosf_pkg::NUM_GAIN) ? TYPE_COUNT
                                                               : cosf_pkg::NUM_GAIN;
  localparam int SQ_SPS  = 2;
  localparam int SQ_LAT  = (32 + SQ_SPS - 1) / SQ_SPS;
  localparam int DIV_SPS = 4;
  localparam int UDIV_NW = 60;
  localparam int UDIV_LAT = (UDIV_NW + DIV_SPS - 1) / DIV_SPS;
  localparam int FDIV_NW = 78;
  localparam int FDIV_LAT = (FDIV_NW + DIV_SPS - 1) / DIV_SPS;
  // A..D, sqrt, unit divide, E..M (7 stages), force divide, N, output
  localparam int VLD_LEN = 4 + SQ_LAT + UDIV_LAT + 7 + FDIV_LAT + 2;

  localparam logic signed [50:0] MAXV = 51'sd2147483647;
  localparam logic signed [50:0] MINV = -51'sd2147483648;
  localparam logic signed [65:0] ONE30 = 66'sd1073741824;

  function automatic logic signed [65:0] tshr30(input logic signed [65:0] v);
    logic [65:0] m;
    m = v[65] ? (66'd0 - v) : v;
    m = m >> 30;
    return v[65] ? $signed(66'd0 - m) : $signed(m);
  endfunction

  function automatic logic over32(input logic signed [50:0] v);
    return (v > MAXV) || (v < MINV);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [50:0] v);
    if (v > MAXV) return 32'sh7fffffff;
    if (v < MINV) return 32'sh80000000;
    return v[31:0];
  endfunction

  // ---------------- handshake and valid track ----------------
  logic               en;
  logic [VLD_LEN-1:0] vld;

  assign en           = !(result_valid && result_stall);
  assign item_stall   = !en;
  assign result_valid = vld[VLD_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[VLD_LEN-2:0], item_valid};
  end

  // ---------------- gain registers ----------------
  logic signed [31:0] gain [GAIN_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GAIN_REGS; i++) gain[i] <= '0;
    end else if (cfg_wr_en) begin
      for (int i = 0; i < GAIN_REGS; i++)
        if (cfg_index == cosf_pkg::CFG_INDEX_W'(i)) gain[i] <= cfg_data;
    end
  end

  // ---------------- stage A: bond differences ----------------
  logic signed [31:0] fpos [3], vpos [3], tpos [3];
  logic [2:0][32:0]   d1_next, d3_next;
  logic signed [31:0] k_next;
  logic [2:0][32:0]   a_d1, a_d3;
  logic               a_z1, a_z3;
  logic signed [31:0] a_k;

  always_comb begin
    fpos[0] = item.first_x;  fpos[1] = item.first_y;  fpos[2] = item.first_z;
    vpos[0] = item.vertex_x; vpos[1] = item.vertex_y; vpos[2] = item.vertex_z;
    tpos[0] = item.third_x;  tpos[1] = item.third_y;  tpos[2] = item.third_z;
    for (int i = 0; i < 3; i++) begin
      d1_next[i] = 33'(fpos[i]) - 33'(vpos[i]);
      d3_next[i] = 33'(tpos[i]) - 33'(vpos[i]);
    end
    // types at or above TYPE_COUNT see a zero gain
    k_next = '0;
    for (int i = 0; i < GAIN_REGS; i++)
      if (item.angle_type == cosf_pkg::TYPE_W'(i)) k_next = gain[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d1 <= d1_next;
      a_d3 <= d3_next;
      a_z1 <= (d1_next == '0);
      a_z3 <= (d3_next == '0);
      a_k  <= k_next;
    end
  end

  // ---------------- stage B: normalize ----------------
  cosf_pkg::bond_t    b_b1, b_b3;
  logic               b_z1, b_z3;
  logic signed [31:0] b_k;

  cosf_norm u_norm1 (.clk(clk), .en(en), .d(a_d1), .q(b_b1));
  cosf_norm u_norm3 (.clk(clk), .en(en), .d(a_d3), .q(b_b3));

  always_ff @(posedge clk) begin
    if (en) begin
      b_z1 <= a_z1;
      b_z3 <= a_z3;
      b_k  <= a_k;
    end
  end

  // ---------------- stage C: squares, stage D: norms ----------------
  logic [59:0]         c_sq1 [3], c_sq3 [3];
  cosf_pkg::pre_root_t c_side, d_side, s_side;
  logic [61:0]         d_sum1, d_sum3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_sq1[i] <= 60'(b_b1.mag[i]) * 60'(b_b1.mag[i]);
        c_sq3[i] <= 60'(b_b3.mag[i]) * 60'(b_b3.mag[i]);
      end
      c_side <= '{b1: b_b1, b3: b_b3, z1: b_z1, z3: b_z3, k: b_k};
      d_sum1 <= 62'(c_sq1[0]) + 62'(c_sq1[1]) + 62'(c_sq1[2]);
      d_sum3 <= 62'(c_sq3[0]) + 62'(c_sq3[1]) + 62'(c_sq3[2]);
      d_side <= c_side;
    end
  end

  // ---------------- square roots ----------------
  logic [31:0] root1, root3;

  cosf_sqrt #(.SPS(SQ_SPS)) u_sqrt1 (.clk(clk), .en(en), .x({2'b00, d_sum1}),
                                     .root(root1));
  cosf_sqrt #(.SPS(SQ_SPS)) u_sqrt3 (.clk(clk), .en(en), .x({2'b00, d_sum3}),
                                     .root(root3));
  cosf_delay #(.WIDTH($bits(cosf_pkg::pre_root_t)), .DEPTH(SQ_LAT)) u_dly_root (
    .clk(clk), .en(en), .d(d_side), .q(s_side)
  );

  // ---------------- unit vectors: n * 2^30 / L ----------------
  cosf_pkg::post_root_t p_side, u_side;
  logic [UDIV_NW-1:0]   uq1 [3], uq3 [3];

  assign p_side = '{neg1: s_side.b1.neg, neg3: s_side.b3.neg,
                    e1: s_side.b1.e, e3: s_side.b3.e,
                    z1: s_side.z1, z3: s_side.z3, k: s_side.k,
                    l1: root1[30:0], l3: root3[30:0]};

  for (genvar i = 0; i < 3; i++) begin : g_unit
    cosf_div #(.NW(UDIV_NW), .DW(31), .SPS(DIV_SPS)) u_div1 (
      .clk(clk), .en(en), .num({s_side.b1.mag[i], 30'd0}), .den(root1[30:0]),
      .quo(uq1[i])
    );
    cosf_div #(.NW(UDIV_NW), .DW(31), .SPS(DIV_SPS)) u_div3 (
      .clk(clk), .en(en), .num({s_side.b3.mag[i], 30'd0}), .den(root3[30:0]),
      .quo(uq3[i])
    );
  end

  cosf_delay #(.WIDTH($bits(cosf_pkg::post_root_t)), .DEPTH(UDIV_LAT)) u_dly_unit (
    .clk(clk), .en(en), .d(p_side), .q(u_side)
  );

  // ---------------- stages E..M: cosine, gradients, gain ----------------
  logic signed [31:0]   e_u1 [3], e_u3 [3], f_u1 [3], f_u3 [3];
  logic signed [31:0]   g_u1 [3], g_u3 [3], h_u1 [3], h_u3 [3];
  logic signed [63:0]   f_p [3], h_p1 [3], h_p3 [3];
  logic signed [31:0]   g_c, h_c, i_c;
  logic signed [32:0]   i_g1 [3], i_g3 [3];
  logic signed [64:0]   j_a1 [3], j_a3 [3], j_ep;
  logic [62:0]          m_mag1 [3], m_mag3 [3];
  cosf_pkg::post_root_t e_side, f_side, g_side, h_side, i_side, j_side;
  cosf_pkg::tail_t      m_tail, t_tail;
  logic [30:0]          m_l1, m_l3;
  logic signed [65:0]   dot_sum, dot_c;
  logic signed [32:0]   c_op;

  always_comb begin
    dot_sum = 66'(f_p[0]) + 66'(f_p[1]) + 66'(f_p[2]);
    dot_c   = tshr30(dot_sum);
    c_op    = 33'(i_c) + 33'sd1073741824;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // E: signed unit components
      for (int i = 0; i < 3; i++) begin
        e_u1[i] <= u_side.neg1[i] ? -$signed({1'b0, uq1[i][30:0]})
                                  :  $signed({1'b0, uq1[i][30:0]});
        e_u3[i] <= u_side.neg3[i] ? -$signed({1'b0, uq3[i][30:0]})
                                  :  $signed({1'b0, uq3[i][30:0]});
      end
      e_side <= u_side;
      // F: dot products
      for (int i = 0; i < 3; i++) f_p[i] <= 64'(e_u1[i]) * 64'(e_u3[i]);
      f_u1 <= e_u1; f_u3 <= e_u3; f_side <= e_side;
      // G: cosine, clamped to [-1, 1]
      if (dot_c > ONE30)       g_c <= 32'sh40000000;
      else if (dot_c < -ONE30) g_c <= -32'sh40000000;
      else                     g_c <= dot_c[31:0];
      g_u1 <= f_u1; g_u3 <= f_u3; g_side <= f_side;
      // H: c * u
      for (int i = 0; i < 3; i++) begin
        h_p1[i] <= 64'(g_c) * 64'(g_u1[i]);
        h_p3[i] <= 64'(g_c) * 64'(g_u3[i]);
      end
      h_u1 <= g_u1; h_u3 <= g_u3; h_c <= g_c; h_side <= g_side;
      // I: gradient directions
      for (int i = 0; i < 3; i++) begin
        i_g1[i] <= 33'(tshr30(66'(h_p1[i]))) - 33'(h_u3[i]);
        i_g3[i] <= 33'(tshr30(66'(h_p3[i]))) - 33'(h_u1[i]);
      end
      i_c <= h_c; i_side <= h_side;
      // J: gain products
      for (int i = 0; i < 3; i++) begin
        j_a1[i] <= 65'($signed(i_side.k)) * 65'(i_g1[i]);
        j_a3[i] <= 65'($signed(i_side.k)) * 65'(i_g3[i]);
      end
      j_ep   <= 65'($signed(i_side.k)) * 65'(c_op);
      j_side <= i_side;
      // M: magnitudes for the dividers, energy truncation
      for (int i = 0; i < 3; i++) begin
        m_mag1[i]      <= j_a1[i][64] ? 63'(-j_a1[i]) : 63'(j_a1[i]);
        m_mag3[i]      <= j_a3[i][64] ? 63'(-j_a3[i]) : 63'(j_a3[i]);
        m_tail.neg1[i] <= j_a1[i][64];
        m_tail.neg3[i] <= j_a3[i][64];
      end
      m_tail.e1     <= j_side.e1;
      m_tail.e3     <= j_side.e3;
      m_tail.z      <= j_side.z1 || j_side.z3;
      m_tail.energy <= 34'(tshr30(66'(j_ep)));
      m_l1 <= j_side.l1;
      m_l3 <= j_side.l3;
    end
  end

  // ---------------- force dividers: |K g| * 2^15 / L ----------------
  logic [FDIV_NW-1:0] fq1 [3], fq3 [3];

  for (genvar i = 0; i < 3; i++) begin : g_force
    cosf_div #(.NW(FDIV_NW), .DW(31), .SPS(DIV_SPS)) u_fdiv1 (
      .clk(clk), .en(en), .num({m_mag1[i], 15'd0}), .den(m_l1), .quo(fq1[i])
    );
    cosf_div #(.NW(FDIV_NW), .DW(31), .SPS(DIV_SPS)) u_fdiv3 (
      .clk(clk), .en(en), .num({m_mag3[i], 15'd0}), .den(m_l3), .quo(fq3[i])
    );
  end

  cosf_delay #(.WIDTH($bits(cosf_pkg::tail_t)), .DEPTH(FDIV_LAT)) u_dly_force (
    .clk(clk), .en(en), .d(m_tail), .q(t_tail)
  );

  // ---------------- stage N: exponent shift and sign ----------------
  // shift by 15 - (e - 14) = 29 - e undoes the bond scaling
  logic [5:0]         sh1, sh3;
  logic [48:0]        q1 [3], q3 [3];
  logic signed [49:0] n_f1 [3], n_f3 [3];
  logic signed [33:0] n_en;
  logic               n_z;

  always_comb begin
    sh1 = 6'd29 - t_tail.e1;
    sh3 = 6'd29 - t_tail.e3;
    for (int i = 0; i < 3; i++) begin
      q1[i] = fq1[i][48:0] >> sh1;
      q3[i] = fq3[i][48:0] >> sh3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_f1[i] <= t_tail.neg1[i] ? -$signed({1'b0, q1[i]}) : $signed({1'b0, q1[i]});
        n_f3[i] <= t_tail.neg3[i] ? -$signed({1'b0, q3[i]}) : $signed({1'b0, q3[i]});
      end
      n_en <= t_tail.energy;
      n_z  <= t_tail.z;
    end
  end

  // ---------------- output register: vertex force, saturation ----------------
  logic signed [50:0] fv [3];
  logic signed [50:0] w1 [3], w3 [3], wen;
  cosf_pkg::result_t  result_next;
  logic               sat;

  always_comb begin
    wen = 51'(n_en);
    sat = over32(wen);
    for (int i = 0; i < 3; i++) begin
      w1[i] = 51'(n_f1[i]);
      w3[i] = 51'(n_f3[i]);
      fv[i] = -(w1[i] + w3[i]);
      sat = sat | over32(w1[i]) | over32(w3[i]) | over32(fv[i]);
    end
    result_next.energy         = clip32(wen);
    result_next.force_first_x  = clip32(w1[0]);
    result_next.force_first_y  = clip32(w1[1]);
    result_next.force_first_z  = clip32(w1[2]);
    result_next.force_vertex_x = clip32(fv[0]);
    result_next.force_vertex_y = clip32(fv[1]);
    result_next.force_vertex_z = clip32(fv[2]);
    result_next.force_third_x  = clip32(w3[0]);
    result_next.force_third_y  = clip32(w3[1]);
    result_next.force_third_z  = clip32(w3[2]);
    result_next.degenerate     = 1'b0;
    result_next.saturated      = sat;
    // zero-length bond: flag only, everything else zero
    if (n_z) begin
      result_next            = '0;
      result_next.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) result <= result_next;
  end

  // ---------------- assertions ----------------
  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled without output backpressure");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.degenerate) |->
      (!result.saturated && result.energy == 32'sd0 && result.force_first_x == 32'sd0))
    else $error("degenerate result not zeroed");

  a_vertex_sum: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.degenerate && !result.saturated) |->
      (result.force_vertex_x == -(result.force_first_x + result.force_third_x)))
    else $error("vertex force is not the negated sum");

endmodule
`default_nettype wire

### rtl/core/cosf_delay.sv
// Enabled shift line that keeps side data aligned with a pipelined unit.
// Depends on nothing.
`default_nettype none
module cosf_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];

endmodule
`default_nettype wire

### rtl/core/cosf_norm.sv
// Registered normalizer: scales a nonzero bond vector so its largest magnitude
// lies in [2^29, 2^30). Depends on cosf_pkg.
`default_nettype none
module cosf_norm (
  input  logic             clk,
  input  logic             en,
  input  logic [2:0][32:0] d,
  output cosf_pkg::bond_t  q
);

  logic [32:0]     m [3];
  logic [32:0]     mx;
  logic [32:0]     sh;
  logic [5:0]      p;
  cosf_pkg::bond_t q_next;

  always_comb begin
    for (int i = 0; i < 3; i++) m[i] = d[i][32] ? (33'd0 - d[i]) : d[i];
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    p = '0;
    for (int b = 0; b < 33; b++) if (mx[b]) p = 6'(b);
    for (int i = 0; i < 3; i++) begin
      if (p >= 6'd29) sh = m[i] >> (p - 6'd29);
      else            sh = m[i] << (6'd29 - p);
      q_next.mag[i] = sh[29:0];
      q_next.neg[i] = d[i][32];
    end
    q_next.e = $signed(6'd29 - p);
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end

endmodule
`default_nettype wire

### rtl/core/cosf_sqrt.sv
// Pipelined digit-by-digit integer square root, SPS digits per stage.
// Depends on nothing.
`default_nettype none
module cosf_sqrt #(
  parameter int SPS = 2
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] x,
  output logic [31:0] root
);

  localparam int NSTEP = 32;
  localparam int NSTG  = (NSTEP + SPS - 1) / SPS;

  logic [63:0] x_r [NSTG];
  logic [63:0] r_r [NSTG];
  logic [63:0] x_in [NSTG];
  logic [63:0] r_in [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [63:0] x_n, r_n;
    if (s == 0) begin : g_first
      assign x_in[s] = x;
      assign r_in[s] = '0;
    end else begin : g_next
      assign x_in[s] = x_r[s-1];
      assign r_in[s] = r_r[s-1];
    end
    always_comb begin
      logic [63:0] bw;
      x_n = x_in[s];
      r_n = r_in[s];
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < NSTEP) begin
          bw = 64'd1 << (62 - 2 * (s * SPS + j));
          if (x_n >= r_n + bw) begin
            x_n = x_n - (r_n + bw);
            r_n = (r_n >> 1) + bw;
          end else begin
            r_n = r_n >> 1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s] <= x_n;
        r_r[s] <= r_n;
      end
    end
  end

  assign root = r_r[NSTG-1][31:0];

endmodule
`default_nettype wire

### rtl/core/cosf_div.sv
// Pipelined restoring unsigned divider, SPS quotient bits per stage.
// Depends on nothing.
`default_nettype none
module cosf_div #(
  parameter int NW  = 60,
  parameter int DW  = 31,
  parameter int SPS = 4
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  localparam int NSTG = (NW + SPS - 1) / SPS;

  logic [DW:0]   r_r [NSTG];
  logic [NW-1:0] q_r [NSTG];
  logic [DW-1:0] d_r [NSTG];
  logic [DW:0]   r_in [NSTG];
  logic [NW-1:0] q_in [NSTG];
  logic [DW-1:0] d_in [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [DW:0]   r_n;
    logic [NW-1:0] q_n;
    if (s == 0) begin : g_first
      assign r_in[s] = '0;
      assign q_in[s] = num;
      assign d_in[s] = den;
    end else begin : g_next
      assign r_in[s] = r_r[s-1];
      assign q_in[s] = q_r[s-1];
      assign d_in[s] = d_r[s-1];
    end
    always_comb begin
      logic [DW:0] t;
      logic        ge;
      r_n = r_in[s];
      q_n = q_in[s];
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < NW) begin
          t   = {r_n[DW-1:0], q_n[NW-1]};
          ge  = (t >= {1'b0, d_in[s]});
          q_n = {q_n[NW-2:0], ge};
          r_n = ge ? (t - {1'b0, d_in[s]}) : t;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[s] <= r_n;
        q_r[s] <= q_n;
        d_r[s] <= d_in[s];
      end
    end
  end

  assign quo = q_r[NSTG-1];

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for cosine_angle_force: streams angle transactions,
// predicts energy, forces and flags in fixed point, checks results in order.
// Depends on cosf_pkg and the cosine_angle_force RTL only.
module testbench;

  typedef longint vec3_t[3];

  // gain register indexes
  localparam logic [cosf_pkg::CFG_INDEX_W-1:0] GAIN_TYPE0 = 2'd0;
  localparam logic [cosf_pkg::CFG_INDEX_W-1:0] GAIN_TYPE1 = 2'd1;
  localparam logic [cosf_pkg::CFG_INDEX_W-1:0] GAIN_TYPE2 = 2'd2;
  localparam logic [cosf_pkg::CFG_INDEX_W-1:0] GAIN_TYPE3 = 2'd3;
  localparam longint ONE_Q30     = 64'sd1 <<< 30;
  localparam longint FORCE_LIMIT = 64'sd1 <<< 61;
  localparam int     PIPE_DRAIN  = 80;   // covers the pipeline depth, plus margin

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             item_valid = 1'b0;
  logic                             item_stall;
  cosf_pkg::item_t                  item = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  cosf_pkg::result_t                result;
  logic                             cfg_wr_en = 1'b0;
  logic [cosf_pkg::CFG_INDEX_W-1:0] cfg_index = GAIN_TYPE0;
  logic [31:0]                      cfg_data = '0;

  longint            gain_q16[cosf_pkg::NUM_GAIN];   // shadow copy of the stiffness registers
  cosf_pkg::result_t pending_results[$];   // predicted results, oldest first
  int                errors = 0;
  int                send_idle_pct = 0;    // sender gap chance per cycle, percent
  int                stall_pct = 0;        // receiver stall chance per cycle, percent
  int                hold_cycles = 0;      // forced receiver hold-off still to run

  cosine_angle_force i_dut (
    .clk, .rst, .item_valid, .item_stall, .item,
    .result_valid, .result_stall, .result,
    .cfg_wr_en, .cfg_index, .cfg_data
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint signed_mag(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // shift right with truncation toward zero
  function automatic longint shr_toward_zero(longint v, int k);
    return signed_mag(magnitude(v) >> k, v < 0);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // scale so the largest component magnitude lands in [2^29, 2^30)
  function automatic int scale_bond(vec3_t d, output vec3_t n);
    longint unsigned m, mm;
    int e;
    m = 0;
    e = 0;
    for (int i = 0; i < 3; i++) if (magnitude(d[i]) > m) m = magnitude(d[i]);
    while (m >= (64'd1 << 30)) begin m >>= 1; e--; end
    while (m < (64'd1 << 29)) begin m <<= 1; e++; end
    for (int i = 0; i < 3; i++) begin
      mm = magnitude(d[i]);
      mm = (e < 0) ? (mm >> (-e)) : (mm << e);
      n[i] = signed_mag(mm, d[i] < 0);
    end
    return e;
  endfunction

  // trunc(a * 2^k / len), magnitude limited to 2^61
  function automatic longint force_scale(longint a, longint unsigned len, int k);
    longint unsigned m, q, r;
    m = magnitude(a);
    if (k < 0) begin
      q = (m / len) >> (-k);
    end else begin
      r = m % len;
      q = m / len;
      if (q > (longint'(FORCE_LIMIT) >> k)) q = FORCE_LIMIT;
      else q = (q << k) + ((r << k) / len);
    end
    if (q > FORCE_LIMIT) q = FORCE_LIMIT;
    return signed_mag(q, a < 0);
  endfunction

  function automatic logic [31:0] clip32(longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin clipped = 1'b1; v = 64'sd2147483647; end
    if (v < -64'sd2147483648) begin clipped = 1'b1; v = -64'sd2147483648; end
    return v[31:0];
  endfunction

  function automatic cosf_pkg::result_t predict_angle(cosf_pkg::item_t a);
    vec3_t d1, d3, n1, n3, u1, u3, f1, f3;
    longint first_p[3], vert_p[3], third_p[3];
    longint unsigned l1, l3;
    longint k, c, g1, g3;
    int e1, e3;
    bit z1, z3, clipped;
    cosf_pkg::result_t r;
    r = '0;
    first_p = '{longint'(a.first_x), longint'(a.first_y), longint'(a.first_z)};
    vert_p  = '{longint'(a.vertex_x), longint'(a.vertex_y), longint'(a.vertex_z)};
    third_p = '{longint'(a.third_x), longint'(a.third_y), longint'(a.third_z)};
    z1 = 1'b1;
    z3 = 1'b1;
    for (int i = 0; i < 3; i++) begin
      d1[i] = first_p[i] - vert_p[i];
      d3[i] = third_p[i] - vert_p[i];
      if (d1[i] != 0) z1 = 1'b0;
      if (d3[i] != 0) z3 = 1'b0;
    end
    if (z1 || z3) begin
      r.degenerate = 1'b1;
      return r;
    end
    k  = (a.angle_type < cosf_pkg::NUM_GAIN) ? gain_q16[a.angle_type] : 0;
    e1 = scale_bond(d1, n1);
    e3 = scale_bond(d3, n3);
    l1 = int_sqrt(n1[0]*n1[0] + n1[1]*n1[1] + n1[2]*n1[2]);
    l3 = int_sqrt(n3[0]*n3[0] + n3[1]*n3[1] + n3[2]*n3[2]);
    c = 0;
    for (int i = 0; i < 3; i++) begin
      u1[i] = signed_mag((magnitude(n1[i]) << 30) / l1, n1[i] < 0);
      u3[i] = signed_mag((magnitude(n3[i]) << 30) / l3, n3[i] < 0);
    end
    for (int i = 0; i < 3; i++) c += u1[i] * u3[i];
    c = shr_toward_zero(c, 30);
    if (c > ONE_Q30) c = ONE_Q30;
    if (c < -ONE_Q30) c = -ONE_Q30;
    for (int i = 0; i < 3; i++) begin
      g1 = shr_toward_zero(c * u1[i], 30) - u3[i];
      g3 = shr_toward_zero(c * u3[i], 30) - u1[i];
      f1[i] = force_scale(k * g1, l1, e1 - 14);
      f3[i] = force_scale(k * g3, l3, e3 - 14);
    end
    clipped = 1'b0;
    r.energy         = clip32(shr_toward_zero(k * (ONE_Q30 + c), 30), clipped);
    r.force_first_x  = clip32(f1[0], clipped);
    r.force_first_y  = clip32(f1[1], clipped);
    r.force_first_z  = clip32(f1[2], clipped);
    r.force_vertex_x = clip32(-(f1[0] + f3[0]), clipped);
    r.force_vertex_y = clip32(-(f1[1] + f3[1]), clipped);
    r.force_vertex_z = clip32(-(f1[2] + f3[2]), clipped);
    r.force_third_x  = clip32(f3[0], clipped);
    r.force_third_y  = clip32(f3[1], clipped);
    r.force_third_z  = clip32(f3[2], clipped);
    r.saturated      = clipped;
    return r;
  endfunction

  // ------------------------------------------------------------ result check

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      errors++;
    end
  endfunction

  // receiver stall pattern, including the forced hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cosf_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("energy",         want.energy,         result.energy);
        check_field("force_first_x",  want.force_first_x,  result.force_first_x);
        check_field("force_first_y",  want.force_first_y,  result.force_first_y);
        check_field("force_first_z",  want.force_first_z,  result.force_first_z);
        check_field("force_vertex_x", want.force_vertex_x, result.force_vertex_x);
        check_field("force_vertex_y", want.force_vertex_y, result.force_vertex_y);
        check_field("force_vertex_z", want.force_vertex_z, result.force_vertex_z);
        check_field("force_third_x",  want.force_third_x,  result.force_third_x);
        check_field("force_third_y",  want.force_third_y,  result.force_third_y);
        check_field("force_third_z",  want.force_third_z,  result.force_third_z);
        check_field("degenerate",     32'(want.degenerate), 32'(result.degenerate));
        check_field("saturated",      32'(want.saturated),  32'(result.saturated));
      end
    end
  end

  // ----------------------------------------------------------------- stimulus

  task automatic send_angle(cosf_pkg::item_t a);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= a;
    do @(posedge clk); while (item_stall);
    pending_results.push_back(predict_angle(a));
  endtask

  // stop sending and wait until every result is in and the pipe is empty
  task automatic drain;
    @(negedge clk);
    item_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_gain(logic [cosf_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    gain_q16[idx] = longint'($signed(value));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_gains(logic [31:0] g0, logic [31:0] g1, logic [31:0] g2,
                           logic [31:0] g3);
    write_gain(GAIN_TYPE0, g0);
    write_gain(GAIN_TYPE1, g1);
    write_gain(GAIN_TYPE2, g2);
    write_gain(GAIN_TYPE3, g3);
  endtask

  function automatic cosf_pkg::item_t make_angle(logic [1:0] t, logic [31:0] vx,
      logic [31:0] vy, logic [31:0] vz, logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
      logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
    cosf_pkg::item_t a;
    a.angle_type = t;
    a.vertex_x = vx; a.vertex_y = vy; a.vertex_z = vz;
    a.first_x  = vx + ax; a.first_y = vy + ay; a.first_z = vz + az;
    a.third_x  = vx + bx; a.third_y = vy + by; a.third_z = vz + bz;
    return a;
  endfunction

  // bond offset with a random size from one LSB up to the full range
  function automatic logic [31:0] rand_offset();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic cosf_pkg::item_t random_angle();
    cosf_pkg::item_t a;
    logic [319:0]    raw;
    if ($urandom_range(0, 99) < 20) begin
      // fully random coordinates: wide bonds, all bits toggle
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
      a = raw[$bits(cosf_pkg::item_t)-1:0];
    end else begin
      a = make_angle(2'($urandom), $urandom, $urandom, $urandom,
                     rand_offset(), rand_offset(), rand_offset(),
                     rand_offset(), rand_offset(), rand_offset());
      // occasional collapsed bond
      if ($urandom_range(0, 99) < 3) begin
        a.first_x = a.vertex_x; a.first_y = a.vertex_y; a.first_z = a.vertex_z;
      end
    end
    return a;
  endfunction

  function automatic logic [31:0] random_gain(int mode);
    case (mode)
      0: begin
        return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      end
      1: begin
        return $urandom;
      end
      default: begin
        return $signed($urandom) >>> $urandom_range(0, 31);
      end
    endcase
  endfunction

  // ------------------------------------------------------------------- tests

  // extremes, each angle type, collinear and right angles, collapsed bonds
  task automatic test_directed;
    set_gains(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_angle(make_angle(2'd0, 0, 0, 0, 0, 0, 0, 32'h1_0000, 0, 0));   // first on vertex
    send_angle(make_angle(2'd1, 5, 6, 7, 32'h1_0000, 0, 0, 0, 0, 0));   // third on vertex
    send_angle(make_angle(2'd2, 9, 9, 9, 0, 0, 0, 0, 0, 0));            // both collapsed
    send_angle(make_angle(2'd0, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 0));
    send_angle(make_angle(2'd1, 0, 0, 0, 32'h1_0000, 0, 0, 32'h2_0000, 0, 0));
    send_angle(make_angle(2'd2, 0, 0, 0, 32'h1_0000, 0, 0, 32'hFFFF_0000, 0, 0));
    send_angle(make_angle(2'd3, 0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 0, 32'h3_0000));
    send_angle(make_angle(2'd2, 0, 0, 0, 1, 0, 0, 0, 1, 0));            // one-LSB bonds
    send_angle(make_angle(2'd3, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 0));
    begin
      cosf_pkg::item_t a;
      a = '{angle_type: 2'd0,
            first_x: 32'h7FFF_FFFF, first_y: 32'h8000_0000, first_z: 32'h7FFF_FFFF,
            vertex_x: 32'h8000_0000, vertex_y: 32'h7FFF_FFFF, vertex_z: 32'h8000_0000,
            third_x: 32'h8000_0000, third_y: 32'h8000_0000, third_z: 32'h7FFF_FFFF};
      send_angle(a);
      a.angle_type = 2'd2;
      a.vertex_x = 32'h7FFF_FFFF;
      send_angle(a);
      a = '{angle_type: 2'd3, default: 32'hFFFF_FFFF};
      a.first_x = 32'h0;
      a.third_z = 32'h8000_0000;
      send_angle(a);
    end
    for (int t = 0; t < cosf_pkg::NUM_GAIN; t++)
      send_angle(make_angle(2'(t), 32'h1234_5678, 32'hEDCB_A987, 32'h0, 32'h3_8000,
                            32'hFFFE_0000, 32'h0_4000, 32'hFFFF_C000, 32'h2_0000,
                            32'h5_0000));
    drain();
  endtask

  // random angles under one gain setting and one idling pattern
  task automatic test_random(int count, int gain_mode, int idle, int stall);
    set_gains(random_gain(gain_mode), random_gain(gain_mode),
              random_gain(gain_mode), random_gain(gain_mode));
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) send_angle(random_angle());
    drain();
  endtask

  // receiver holds off long enough that the pipe fills and stalls the input
  task automatic test_backpressure;
    set_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, random_gain(0));
    send_idle_pct = 0;
    stall_pct     = 0;
    @(negedge clk);
    hold_cycles = 200;
    repeat (150) send_angle(random_angle());
    drain();
  endtask

  // sender pauses until every result is back, then resumes
  task automatic test_pause;
    send_idle_pct = 10;
    stall_pct     = 10;
    repeat (40) send_angle(random_angle());
    drain();
    repeat (40) send_angle(random_angle());
    drain();
  endtask

  initial begin
    for (int i = 0; i < cosf_pkg::NUM_GAIN; i++) gain_q16[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(300, 0, 0, 0);
    test_random(300, 2, 50, 0);
    test_random(300, 0, 0, 50);
    test_random(300, 1, 20, 20);
    test_random(250, 2, 0, 0);
    test_backpressure();
    test_pause();
    test_random(200, 0, 50, 50);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
